[sv/sha_pkg.sv]
// ============================================================================
// sha_pkg
// Shared types, constants and the round constant table for the SHA-256
// streaming hasher.
// ============================================================================
package sha_pkg;

    localparam int unsigned WORD_W          = 32;
    localparam int unsigned WORDS_PER_BLOCK = 16;
    localparam int unsigned ROUND_W         = 6;

    // Eight 32-bit words: hash state or working variables, index 0 is a / H0
    typedef logic [7:0][WORD_W-1:0] word8_t;

    typedef struct packed {
        logic shift;    // push load_word into the schedule line
        logic expand;   // push the next expanded schedule word
    } sched_ctl_t;

    typedef struct packed {
        logic init;     // copy the hash state into the working variables
        logic step;     // run one compression round
    } round_ctl_t;

    // Schedule slots that carry the 64-bit message length
    localparam logic [3:0] LEN_HI_IDX = 4'd14;
    localparam logic [3:0] LEN_LO_IDX = 4'd15;
    localparam logic [3:0] LAST_IDX   = 4'd15;

    localparam logic [ROUND_W-1:0] LAST_ROUND = 6'd63;

    localparam logic [WORD_W-1:0] PAD_MARK = 32'h8000_0000;

    function automatic word8_t h_init();
        word8_t h;
        h[0] = 32'h6A09E667;
        h[1] = 32'hBB67AE85;
        h[2] = 32'h3C6EF372;
        h[3] = 32'hA54FF53A;
        h[4] = 32'h510E527F;
        h[5] = 32'h9B05688C;
        h[6] = 32'h1F83D9AB;
        h[7] = 32'h5BE0CD19;
        return h;
    endfunction

    function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] idx);
        logic [WORD_W-1:0] k;
        case (idx)
            6'd0:  k = 32'h428A2F98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hB5C0FBCF;  6'd3:  k = 32'hE9B5DBA5;
            6'd4:  k = 32'h3956C25B;  6'd5:  k = 32'h59F111F1;
            6'd6:  k = 32'h923F82A4;  6'd7:  k = 32'hAB1C5ED5;
            6'd8:  k = 32'hD807AA98;  6'd9:  k = 32'h12835B01;
            6'd10: k = 32'h243185BE;  6'd11: k = 32'h550C7DC3;
            6'd12: k = 32'h72BE5D74;  6'd13: k = 32'h80DEB1FE;
            6'd14: k = 32'h9BDC06A7;  6'd15: k = 32'hC19BF174;
            6'd16: k = 32'hE49B69C1;  6'd17: k = 32'hEFBE4786;
            6'd18: k = 32'h0FC19DC6;  6'd19: k = 32'h240CA1CC;
            6'd20: k = 32'h2DE92C6F;  6'd21: k = 32'h4A7484AA;
            6'd22: k = 32'h5CB0A9DC;  6'd23: k = 32'h76F988DA;
            6'd24: k = 32'h983E5152;  6'd25: k = 32'hA831C66D;
            6'd26: k = 32'hB00327C8;  6'd27: k = 32'hBF597FC7;
            6'd28: k = 32'hC6E00BF3;  6'd29: k = 32'hD5A79147;
            6'd30: k = 32'h06CA6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27B70A85;  6'd33: k = 32'h2E1B2138;
            6'd34: k = 32'h4D2C6DFC;  6'd35: k = 32'h53380D13;
            6'd36: k = 32'h650A7354;  6'd37: k = 32'h766A0ABB;
            6'd38: k = 32'h81C2C92E;  6'd39: k = 32'h92722C85;
            6'd40: k = 32'hA2BFE8A1;  6'd41: k = 32'hA81A664B;
            6'd42: k = 32'hC24B8B70;  6'd43: k = 32'hC76C51A3;
            6'd44: k = 32'hD192E819;  6'd45: k = 32'hD6990624;
            6'd46: k = 32'hF40E3585;  6'd47: k = 32'h106AA070;
            6'd48: k = 32'h19A4C116;  6'd49: k = 32'h1E376C08;
            6'd50: k = 32'h2748774C;  6'd51: k = 32'h34B0BCB5;
            6'd52: k = 32'h391C0CB3;  6'd53: k = 32'h4ED8AA4A;
            6'd54: k = 32'h5B9CCA4F;  6'd55: k = 32'h682E6FF3;
            6'd56: k = 32'h748F82EE;  6'd57: k = 32'h78A5636F;
            6'd58: k = 32'h84C87814;  6'd59: k = 32'h8CC70208;
            6'd60: k = 32'h90BEFFFA;  6'd61: k = 32'hA4506CEB;
            6'd62: k = 32'hBEF9A3F7;  6'd63: k = 32'hC67178F2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

[sv/sha256_stream_hasher.sv]
// ============================================================================
// sha256_stream_hasher
// Streaming SHA-256 over big-endian 32-bit message words.
// ============================================================================
// Words are taken one per cycle while in_ready is high until a 64-byte block
// is full; the sixteenth word starts a compression on the single round unit,
// which runs the rounds in turn and then folds the result into the hash state;
// in_ready stays low during compression.
// A word marked last also starts finishing: the rest of the block is filled
// with the 0x80 marker, zeros and the 64-bit bit length at one word per cycle,
// using an extra block when the marker lands past byte 55, then the digest is
// moved into the output register and the hash state reset. That register holds
// the digest until out_ready takes it while new words are already accepted; a
// later digest waits for it.
// ============================================================================
module sha256_stream_hasher
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] data_word,
    input  logic [2:0]  valid_bytes,
    input  logic        last_word,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_0,
    output logic [63:0] digest_1,
    output logic [63:0] digest_2,
    output logic [63:0] digest_3
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]                     state_reg, state_next;
    logic [3:0]                     wc_reg, wc_next;
    logic [sha_pkg::ROUND_W-1:0]    round_reg, round_next;
    logic [63:0]                    bits_reg, bits_next;
    sha_pkg::word8_t                hash_reg, hash_next;
    logic                           fin_reg, fin_next;
    logic                           mark_done_reg, mark_done_next;
    logic                           len_here_reg, len_here_next;
    logic                           len_done_reg, len_done_next;
    logic                           out_valid_reg, out_valid_next;
    logic [63:0]                    dig_reg [4];

    logic                           in_xfer;
    logic [2:0]                     n_eff;
    logic [31:0]                    last_fill;
    logic [31:0]                    pad_word;
    logic                           out_load;

    sha_pkg::sched_ctl_t            sched_ctl;
    sha_pkg::round_ctl_t            round_ctl;
    logic [31:0]                    load_word;
    logic [31:0]                    w_cur;
    sha_pkg::word8_t                vars;

    assign in_xfer = in_valid && in_ready;

    // Bytes taken from the last word; counts above four mean a full word
    always_comb
    begin
        n_eff = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
        case (n_eff)
            3'd0:    last_fill = sha_pkg::PAD_MARK;
            3'd1:    last_fill = {data_word[31:24], 24'h80_0000};
            3'd2:    last_fill = {data_word[31:16], 16'h8000};
            3'd3:    last_fill = {data_word[31:8], 8'h80};
            default: last_fill = data_word;
        endcase

        if (!mark_done_reg)
        begin
            pad_word = sha_pkg::PAD_MARK;
        end
        else if (len_here_reg && (wc_reg == sha_pkg::LEN_HI_IDX))
        begin
            pad_word = bits_reg[63:32];
        end
        else if (len_here_reg && (wc_reg == sha_pkg::LEN_LO_IDX))
        begin
            pad_word = bits_reg[31:0];
        end
        else
        begin
            pad_word = 32'h0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        wc_next        = wc_reg;
        round_next     = round_reg;
        bits_next      = bits_reg;
        hash_next      = hash_reg;
        fin_next       = fin_reg;
        mark_done_next = mark_done_reg;
        len_here_next  = len_here_reg;
        len_done_next  = len_done_reg;
        out_valid_next = out_valid_reg;
        out_load       = 1'b0;
        sched_ctl      = '0;
        round_ctl      = '0;
        load_word      = data_word;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    sched_ctl.shift = 1'b1;
                    wc_next         = wc_reg + 4'd1;
                    if (last_word)
                    begin
                        load_word      = last_fill;
                        bits_next      = bits_reg + {58'd0, n_eff, 3'd0};
                        fin_next       = 1'b1;
                        mark_done_next = (n_eff != 3'd4);
                        len_here_next  = (n_eff != 3'd4) && (wc_reg < sha_pkg::LEN_HI_IDX);
                        state_next     = S_PAD;
                    end
                    else
                    begin
                        bits_next = bits_reg + 64'd32;
                    end
                    if (wc_reg == sha_pkg::LAST_IDX)
                    begin
                        round_ctl.init = 1'b1;
                        round_next     = '0;
                        state_next     = S_ROUND;
                    end
                end
            end

            S_PAD:
            begin
                sched_ctl.shift = 1'b1;
                load_word       = pad_word;
                wc_next         = wc_reg + 4'd1;
                if (!mark_done_reg)
                begin
                    mark_done_next = 1'b1;
                    len_here_next  = (wc_reg < sha_pkg::LEN_HI_IDX);
                end
                if (mark_done_reg && len_here_reg && (wc_reg == sha_pkg::LEN_LO_IDX))
                begin
                    len_done_next = 1'b1;
                end
                if (wc_reg == sha_pkg::LAST_IDX)
                begin
                    round_ctl.init = 1'b1;
                    round_next     = '0;
                    state_next     = S_ROUND;
                end
            end

            S_ROUND:
            begin
                round_ctl.step   = 1'b1;
                sched_ctl.expand = 1'b1;
                round_next       = round_reg + 6'd1;
                if (round_reg == sha_pkg::LAST_ROUND)
                begin
                    state_next = S_ADD;
                end
            end

            S_ADD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_next[i] = hash_reg[i] + vars[i];
                end
                if (fin_reg && len_done_reg)
                begin
                    state_next = S_OUT;
                end
                else if (fin_reg)
                begin
                    // marker already placed: the next block carries the length
                    if (mark_done_reg)
                    begin
                        len_here_next = 1'b1;
                    end
                    state_next = S_PAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_OUT:
            begin
                // hold the digest until the previous one has been taken
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    hash_next      = sha_pkg::h_init();
                    bits_next      = '0;
                    wc_next        = '0;
                    fin_next       = 1'b0;
                    mark_done_next = 1'b0;
                    len_here_next  = 1'b0;
                    len_done_next  = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wc_reg        <= '0;
            round_reg     <= '0;
            bits_reg      <= '0;
            hash_reg      <= sha_pkg::h_init();
            fin_reg       <= 1'b0;
            mark_done_reg <= 1'b0;
            len_here_reg  <= 1'b0;
            len_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wc_reg        <= wc_next;
            round_reg     <= round_next;
            bits_reg      <= bits_next;
            hash_reg      <= hash_next;
            fin_reg       <= fin_next;
            mark_done_reg <= mark_done_next;
            len_here_reg  <= len_here_next;
            len_done_reg  <= len_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            for (int i = 0; i < 4; i++)
            begin
                dig_reg[i] <= {hash_reg[2*i], hash_reg[2*i+1]};
            end
        end
    end

    sha_sched u_sched
    (
        .clk       (clk),
        .ctl       (sched_ctl),
        .load_word (load_word),
        .w_cur     (w_cur)
    );

    sha_round u_round
    (
        .clk     (clk),
        .ctl     (round_ctl),
        .hash_in (hash_reg),
        .w       (w_cur),
        .k       (sha_pkg::round_k(round_reg)),
        .vars    (vars)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign digest_0  = dig_reg[0];
    assign digest_1  = dig_reg[1];
    assign digest_2  = dig_reg[2];
    assign digest_3  = dig_reg[3];

endmodule

[sv/sha_sched.sv]
// ============================================================================
// sha_sched
// Sixteen-word message schedule line. Message words shift in at the top;
// during compression the line expands itself one word per round and the
// oldest word is the round's schedule word.
// ============================================================================
module sha_sched
(
    input  logic                              clk,
    input  sha_pkg::sched_ctl_t               ctl,
    input  logic [sha_pkg::WORD_W-1:0]        load_word,
    output logic [sha_pkg::WORD_W-1:0]        w_cur
);

    logic [sha_pkg::WORD_W-1:0] w_reg [sha_pkg::WORDS_PER_BLOCK];
    logic [sha_pkg::WORD_W-1:0] s0;
    logic [sha_pkg::WORD_W-1:0] s1;
    logic [sha_pkg::WORD_W-1:0] exp_word;
    logic [sha_pkg::WORD_W-1:0] top_next;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    always_comb
    begin
        s0       = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1       = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        exp_word = w_reg[0] + s0 + w_reg[9] + s1;
        top_next = ctl.expand ? exp_word : load_word;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift || ctl.expand)
        begin
            for (int i = 0; i < sha_pkg::WORDS_PER_BLOCK - 1; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[sha_pkg::WORDS_PER_BLOCK-1] <= top_next;
        end
    end

    assign w_cur = w_reg[0];

endmodule

[sv/sha_round.sv]
// ============================================================================
// sha_round
// SHA-256 round unit: holds the working variables a..h and applies one
// compression round per step.
// ============================================================================
module sha_round
(
    input  logic                              clk,
    input  sha_pkg::round_ctl_t               ctl,
    input  sha_pkg::word8_t                   hash_in,
    input  logic [sha_pkg::WORD_W-1:0]        w,
    input  logic [sha_pkg::WORD_W-1:0]        k,
    output sha_pkg::word8_t                   vars
);

    sha_pkg::word8_t            vars_reg;
    sha_pkg::word8_t            vars_next;
    logic [sha_pkg::WORD_W-1:0] big_s0;
    logic [sha_pkg::WORD_W-1:0] big_s1;
    logic [sha_pkg::WORD_W-1:0] ch;
    logic [sha_pkg::WORD_W-1:0] maj;
    logic [sha_pkg::WORD_W-1:0] t1;
    logic [sha_pkg::WORD_W-1:0] t2;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    always_comb
    begin
        big_s1 = rotr(vars_reg[4], 6) ^ rotr(vars_reg[4], 11) ^ rotr(vars_reg[4], 25);
        ch     = (vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]);
        t1     = vars_reg[7] + big_s1 + ch + k + w;
        big_s0 = rotr(vars_reg[0], 2) ^ rotr(vars_reg[0], 13) ^ rotr(vars_reg[0], 22);
        maj    = (vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
               ^ (vars_reg[1] & vars_reg[2]);
        t2     = big_s0 + maj;

        vars_next[7] = vars_reg[6];
        vars_next[6] = vars_reg[5];
        vars_next[5] = vars_reg[4];
        vars_next[4] = vars_reg[3] + t1;
        vars_next[3] = vars_reg[2];
        vars_next[2] = vars_reg[1];
        vars_next[1] = vars_reg[0];
        vars_next[0] = t1 + t2;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.init)
        begin
            vars_reg <= hash_in;
        end
        else if (ctl.step)
        begin
            vars_reg <= vars_next;
        end
    end

    assign vars = vars_reg;

endmodule

[sv/sha_checker.sv]
// ============================================================================
// sha_checker
// Port-level checks for the SHA-256 streaming hasher, bound to the top level.
// ============================================================================
module sha_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        last_word,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] digest_0,
    input logic [63:0] digest_1,
    input logic [63:0] digest_2,
    input logic [63:0] digest_3
);

    // A waiting digest stays put until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digest_0) && $stable(digest_1)
            && $stable(digest_2) && $stable(digest_3))
        else $error("digest changed while stalled");

    // A final word always leads into padding or compression
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_word |=> !in_ready)
        else $error("input ready right after final word");

    // A digest appears only at the end of a busy stretch
    a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("digest without finishing work");

    // The block goes busy only because it took a transaction
    a_busy_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
        else $error("input ready dropped without a transaction");

endmodule

bind sha256_stream_hasher sha_checker u_sha_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last_word (last_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .digest_0  (digest_0),
    .digest_1  (digest_1),
    .digest_2  (digest_2),
    .digest_3  (digest_3)
);
